// ===== design/tse_pkg.sv =====
// Package for the TLS server name extractor: constants, codes and shared types.
package tse_pkg;

   localparam int MAX_MESSAGE_BYTES_DEFAULT = 2048;
   localparam logic [8:0] NAME_CAPACITY_RESET = 9'd256;

   localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam logic [7:0] NAME_TYPE_HOST  = 8'h00;
   localparam int FIXED_SKIP = 34;
   localparam int BODY_START = 9;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_NOT_HS   = 3'd1,
      ST_NOT_CH   = 3'd2,
      ST_TRUNC    = 3'd3,
      ST_NO_SNI   = 3'd4,
      ST_BAD_TYPE = 3'd5,
      ST_BAD_NAME = 3'd6
   } status_type;

   typedef enum logic [0:0] {
      KIND_NAME   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [14:0] {
      PH_HEAD     = 15'b000000000000001,
      PH_SID_LEN  = 15'b000000000000010,
      PH_SID_SKIP = 15'b000000000000100,
      PH_CS_HI    = 15'b000000000001000,
      PH_CS_LO    = 15'b000000000010000,
      PH_CS_SKIP  = 15'b000000000100000,
      PH_CM_LEN   = 15'b000000001000000,
      PH_CM_SKIP  = 15'b000000010000000,
      PH_EXT_HI   = 15'b000000100000000,
      PH_EXT_LO   = 15'b000001000000000,
      PH_XHDR     = 15'b000010000000000,
      PH_XSKIP    = 15'b000100000000000,
      PH_SNI_HDR  = 15'b001000000000000,
      PH_NAME     = 15'b010000000000000,
      PH_DONE     = 15'b100000000000000
   } phase_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] name_byte;
      logic [2:0] status;
      logic       last_of_run;
   } result_type;

   // results produced by one input beat: none, one or two
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== design/tse_if.sv =====
// Valid/ready channel interfaces for request bytes and response results.
interface tse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface tse_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] name_byte;
   logic [2:0] status;
   logic       last_of_run;

   modport source (output valid, output result_kind, output name_byte, output status,
                   output last_of_run, input ready);
   modport sink (input valid, input result_kind, input name_byte, input status,
                 input last_of_run, output ready);
endinterface

// ===== design/tse_parser.sv =====
// ClientHello walker: one byte per beat, updates phase and counters, emits results.
module tse_parser #(
   parameter int MAX_MESSAGE_BYTES = tse_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             beat,
   input  logic [7:0]       data_byte,
   input  logic             end_of_buffer,
   input  logic [8:0]       name_capacity,
   output tse_pkg::push_type push
);

   localparam int PosW = ($clog2(MAX_MESSAGE_BYTES) > 6) ? $clog2(MAX_MESSAGE_BYTES) : 6;
   localparam logic [PosW-1:0] PosBody = PosW'(tse_pkg::BODY_START + tse_pkg::FIXED_SKIP - 1);
   localparam logic [PosW-1:0] PosLast = PosW'(MAX_MESSAGE_BYTES - 1);

   tse_pkg::phase_type phase_ff, phase_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] ext_left_ff, ext_left_in;
   logic        is_sni_ff, is_sni_in;
   logic [15:0] name_left_ff, name_left_in;
   logic [7:0]  high_ff, high_in;

   logic        dec;
   logic [2:0]  dec_code;
   logic        name_out;
   logic [15:0] word;
   tse_pkg::result_type name_res, stat_res;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      ext_left_in  = ext_left_ff;
      is_sni_in    = is_sni_ff;
      name_left_in = name_left_ff;
      high_in      = high_ff;
      dec          = 1'b0;
      dec_code     = tse_pkg::ST_FOUND;
      name_out     = 1'b0;
      word         = {high_ff, data_byte};

      if (phase_ff != tse_pkg::PH_DONE) begin
         unique case (phase_ff)
            tse_pkg::PH_HEAD: begin
               if (pos_ff == '0 && data_byte != tse_pkg::REC_HANDSHAKE) begin
                  dec = 1'b1;
                  dec_code = tse_pkg::ST_NOT_HS;
               end else if (pos_ff == PosW'(5) && data_byte != tse_pkg::HS_CLIENT_HELLO) begin
                  dec = 1'b1;
                  dec_code = tse_pkg::ST_NOT_CH;
               end else if (pos_ff >= PosBody) begin
                  phase_in = tse_pkg::PH_SID_LEN;
               end
            end
            tse_pkg::PH_SID_LEN: begin
               skip_in = {8'd0, data_byte};
               phase_in = (data_byte != 8'd0) ? tse_pkg::PH_SID_SKIP : tse_pkg::PH_CS_HI;
            end
            tse_pkg::PH_SID_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) phase_in = tse_pkg::PH_CS_HI;
            end
            tse_pkg::PH_CS_HI: begin
               high_in = data_byte;
               phase_in = tse_pkg::PH_CS_LO;
            end
            tse_pkg::PH_CS_LO: begin
               skip_in = word;
               phase_in = (word != 16'd0) ? tse_pkg::PH_CS_SKIP : tse_pkg::PH_CM_LEN;
            end
            tse_pkg::PH_CS_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) phase_in = tse_pkg::PH_CM_LEN;
            end
            tse_pkg::PH_CM_LEN: begin
               skip_in = {8'd0, data_byte};
               phase_in = (data_byte != 8'd0) ? tse_pkg::PH_CM_SKIP : tse_pkg::PH_EXT_HI;
            end
            tse_pkg::PH_CM_SKIP: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) phase_in = tse_pkg::PH_EXT_HI;
            end
            tse_pkg::PH_EXT_HI: begin
               high_in = data_byte;
               phase_in = tse_pkg::PH_EXT_LO;
            end
            tse_pkg::PH_EXT_LO: begin
               ext_left_in = word;
               if (word < 16'd4) begin
                  dec = 1'b1;
                  dec_code = tse_pkg::ST_NO_SNI;
               end else begin
                  phase_in = tse_pkg::PH_XHDR;
                  skip_in = 16'd0;
               end
            end
            tse_pkg::PH_XHDR: begin
               ext_left_in = ext_left_ff - 16'd1;
               if (skip_ff == 16'd0 || skip_ff == 16'd2) begin
                  high_in = data_byte;
                  skip_in = skip_ff + 16'd1;
               end else if (skip_ff == 16'd1) begin
                  is_sni_in = (word == 16'h0000);
                  skip_in = skip_ff + 16'd1;
               end else if (is_sni_ff) begin
                  if (ext_left_in < 16'd5) begin
                     dec = 1'b1;
                     dec_code = tse_pkg::ST_BAD_NAME;
                  end else begin
                     phase_in = tse_pkg::PH_SNI_HDR;
                     skip_in = 16'd0;
                  end
               end else if (word > ext_left_in) begin
                  dec = 1'b1;
                  dec_code = tse_pkg::ST_NO_SNI;
               end else if (word == 16'd0) begin
                  if (ext_left_in < 16'd4) begin
                     dec = 1'b1;
                     dec_code = tse_pkg::ST_NO_SNI;
                  end else begin
                     skip_in = 16'd0;
                  end
               end else begin
                  phase_in = tse_pkg::PH_XSKIP;
                  skip_in = word;
               end
            end
            tse_pkg::PH_XSKIP: begin
               ext_left_in = ext_left_ff - 16'd1;
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) begin
                  if (ext_left_in < 16'd4) begin
                     dec = 1'b1;
                     dec_code = tse_pkg::ST_NO_SNI;
                  end else begin
                     phase_in = tse_pkg::PH_XHDR;
                  end
               end
            end
            tse_pkg::PH_SNI_HDR: begin
               ext_left_in = ext_left_ff - 16'd1;
               if (skip_ff == 16'd2 && data_byte != tse_pkg::NAME_TYPE_HOST) begin
                  dec = 1'b1;
                  dec_code = tse_pkg::ST_BAD_TYPE;
               end else if (skip_ff == 16'd3) begin
                  high_in = data_byte;
                  skip_in = skip_ff + 16'd1;
               end else if (skip_ff >= 16'd4) begin
                  name_left_in = word;
                  if (word > ext_left_in || word >= {7'd0, name_capacity}) begin
                     dec = 1'b1;
                     dec_code = tse_pkg::ST_BAD_NAME;
                  end else if (word == 16'd0) begin
                     dec = 1'b1;
                     dec_code = tse_pkg::ST_FOUND;
                  end else begin
                     phase_in = tse_pkg::PH_NAME;
                  end
               end else begin
                  skip_in = skip_ff + 16'd1;
               end
            end
            tse_pkg::PH_NAME: begin
               name_out = 1'b1;
               ext_left_in = ext_left_ff - 16'd1;
               name_left_in = name_left_ff - 16'd1;
               if (name_left_in == 16'd0) begin
                  dec = 1'b1;
                  dec_code = tse_pkg::ST_FOUND;
               end
            end
            default: begin
            end
         endcase

         if (dec) phase_in = tse_pkg::PH_DONE;
         pos_in = pos_ff + 1'b1;

         // input end: code follows where the walk now stands
         if (!dec && (end_of_buffer || pos_ff >= PosLast)) begin
            dec = 1'b1;
            if (phase_in == tse_pkg::PH_XHDR || phase_in == tse_pkg::PH_XSKIP)
               dec_code = tse_pkg::ST_NO_SNI;
            else if (phase_in == tse_pkg::PH_SNI_HDR || phase_in == tse_pkg::PH_NAME)
               dec_code = tse_pkg::ST_BAD_NAME;
            else
               dec_code = tse_pkg::ST_TRUNC;
            phase_in = tse_pkg::PH_DONE;
         end
      end

      if (end_of_buffer) begin
         phase_in     = tse_pkg::PH_HEAD;
         pos_in       = '0;
         skip_in      = 16'd0;
         ext_left_in  = 16'd0;
         is_sni_in    = 1'b0;
         name_left_in = 16'd0;
         high_in      = 8'd0;
      end
   end

   always_comb begin
      name_res.result_kind = tse_pkg::KIND_NAME;
      name_res.name_byte   = data_byte;
      name_res.status      = tse_pkg::ST_FOUND;
      name_res.last_of_run = 1'b0;
      stat_res.result_kind = tse_pkg::KIND_STATUS;
      stat_res.name_byte   = 8'd0;
      stat_res.status      = dec_code;
      stat_res.last_of_run = 1'b1;

      push.count  = beat ? ({1'b0, name_out} + {1'b0, dec}) : 2'd0;
      push.first  = name_out ? name_res : stat_res;
      push.second = stat_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tse_pkg::PH_HEAD;
         pos_ff       <= '0;
         skip_ff      <= 16'd0;
         ext_left_ff  <= 16'd0;
         is_sni_ff    <= 1'b0;
         name_left_ff <= 16'd0;
         high_ff      <= 8'd0;
      end else if (beat) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         ext_left_ff  <= ext_left_in;
         is_sni_ff    <= is_sni_in;
         name_left_ff <= name_left_in;
         high_ff      <= high_in;
      end
   end

endmodule

// ===== design/tse_rsp_fifo.sv =====
// Small result queue: takes up to two results a beat, hands out one a cycle while ready.
module tse_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  tse_pkg::push_type push,
   output logic              room,
   tse_rsp_if.source         rsp_bus
);

   tse_pkg::result_type entry_ff [tse_pkg::RSP_DEPTH];
   logic [tse_pkg::RSP_PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [tse_pkg::RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic pop;
   tse_pkg::result_type head;

   assign room = cnt_ff <= tse_pkg::RSP_CNT_W'(tse_pkg::RSP_DEPTH - 2);
   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign head = entry_ff[rd_ff];

   assign rsp_bus.valid       = cnt_ff != '0;
   assign rsp_bus.result_kind = head.result_kind;
   assign rsp_bus.name_byte   = head.name_byte;
   assign rsp_bus.status      = head.status;
   assign rsp_bus.last_of_run = head.last_of_run;

   always_comb begin
      wr_in  = wr_ff + tse_pkg::RSP_PTR_W'(push.count);
      rd_in  = rd_ff + tse_pkg::RSP_PTR_W'(pop);
      cnt_in = cnt_ff + tse_pkg::RSP_CNT_W'(push.count) - tse_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_ff + tse_pkg::RSP_PTR_W'(1)] <= push.second;
   end

endmodule

// ===== design/tls_sni_extractor.sv =====
// A result is queued on the beat that causes it and offered on rsp_bus in order.
// Throughput: one request byte per cycle; a byte may yield two results (last name
// byte plus status), which the four-entry result queue absorbs; req ready drops
// only while the queue holds more than two results.
// Reset: synchronous; clears parse state, empties the queue, capacity back to 256.
module tls_sni_extractor #(
   parameter int MAX_MESSAGE_BYTES = tse_pkg::MAX_MESSAGE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tse_req_if.sink    req_bus,
   tse_rsp_if.source  rsp_bus,
   input  logic       csr_we,
   input  logic [8:0] csr_wdata
);

   logic [8:0] cap_ff;
   logic       room;
   logic       beat;
   tse_pkg::push_type push;

   assign req_bus.ready = room;
   assign beat = req_bus.valid && room;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= tse_pkg::NAME_CAPACITY_RESET;
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   tse_parser #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .beat          (beat),
      .data_byte     (req_bus.data_byte),
      .end_of_buffer (req_bus.end_of_buffer),
      .name_capacity (cap_ff),
      .push          (push)
   );

   tse_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== design/tse_checker.sv =====
// Port-level checks for the extractor, bound to the top level.
module tse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [7:0] rsp_name_byte,
   input logic [2:0] rsp_status,
   input logic       rsp_last_of_run
);

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
         $stable(rsp_name_byte) && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("response beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a name beat carries no status and ends no run; a status beat ends the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_kind == rsp_last_of_run))
      else $error("last_of_run does not match result kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_status == tse_pkg::ST_FOUND)
      else $error("name beat with nonzero status");

   // no request back-pressure without queued results
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty result queue");

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_kind (rsp_bus.result_kind),
   .rsp_name_byte   (rsp_bus.name_byte),
   .rsp_status      (rsp_bus.status),
   .rsp_last_of_run (rsp_bus.last_of_run)
);
